@@ hdl/dspr_pkg.sv @@
// ----------------------------------------------------------------------------
// dspr_pkg: shared types and constants for the dual serial port registers
// Command codes, address field codes, register bit positions and the
// request and result records passed between the pipeline and the register file.
// ----------------------------------------------------------------------------
`default_nettype none

package dspr_pkg;

    localparam int PORT_COUNT = 2;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // address field codes
    localparam logic [1:0] ALIAS_BODY = 2'd0;
    localparam logic [1:0] ALIAS_CLR  = 2'd1;
    localparam logic [1:0] ALIAS_SET  = 2'd2;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_STATUS   = 2'd1;
    localparam logic [1:0] REG_TRANSMIT = 2'd2;
    localparam logic [1:0] REG_RECEIVE  = 2'd3;

    localparam logic [1:0] GRP_ENABLE = 2'd2;
    localparam logic [1:0] GRP_FLAG   = 2'd3;

    // register bit positions
    localparam int MODE_ON_BIT  = 15;
    localparam int STA_URXDA    = 0;
    localparam int STA_TRMT     = 8;
    localparam int STA_UTXEN    = 10;
    localparam int STA_URXEN    = 12;

    localparam logic [31:0] FLAG_RX0 = 32'h0000_0100;
    localparam logic [31:0] FLAG_TX0 = 32'h0000_0200;
    localparam logic [31:0] FLAG_RX1 = 32'h0040_0000;
    localparam logic [31:0] FLAG_TX1 = 32'h0080_0000;
    localparam logic [31:0] FLAG_MASK = FLAG_RX0 | FLAG_TX0 | FLAG_RX1 | FLAG_TX1;

    localparam logic [31:0] RX_FLAG [PORT_COUNT] = '{FLAG_RX0, FLAG_RX1};
    localparam logic [31:0] TX_FLAG [PORT_COUNT] = '{FLAG_TX0, FLAG_TX1};

    localparam logic [31:0] STATUS_RESET = 32'h0000_0100;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // vector number of the processor-side interrupt, not driven out
    localparam int IRQ_VECTOR = 37;

    typedef struct packed {
        logic        cpu_int_open;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic [31:0] write_data;
        logic [5:0]  address;
        cmd_t        command;
    } item_t;

    typedef struct packed {
        logic        irq_raise;
        logic        rx_taken;
        logic [7:0]  tx1_byte;
        logic        tx1_valid;
        logic [7:0]  tx0_byte;
        logic        tx0_valid;
        logic [31:0] read_data;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/dual_serial_port_registers_core.sv @@
// ----------------------------------------------------------------------------
// dual_serial_port_registers_core: two serial ports behind aliased registers
// Bus writes, bus reads and ticks enter as requests; each yields one result.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_axis    in         tuser: command; tdata: address, write_data, rx_valid,
//                       rx_byte, cpu_int_open
//  m_axis    out        tdata: read_data, tx0_valid, tx0_byte, tx1_valid,
//                       tx1_byte, rx_taken, irq_raise
//
//  One request per cycle sustained while the result side does not stall; an
//  accepted request passes the input register, then the register-file pass
//  into the result register, and is then offered on m_axis. The register
//  file pass is the only logic between the stages.
//  Reset returns all registers to their reset values and empties both stages.
//  A stalled result holds the result register; the input register still
//  fills, and further requests wait until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_serial_port_registers_core
    import dspr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [5:0] address, [37:6] write_data, [38] rx_valid, [46:39] rx_byte,
    // [47] cpu_int_open
    input  wire logic [47:0] s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] read_data, [32] tx0_valid, [40:33] tx0_byte, [41] tx1_valid,
    // [49:42] tx1_byte, [50] rx_taken, [51] irq_raise, [55:52] zero
    output      logic [55:0] m_axis_tdata
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_result_reg;
    result_t step_result;
    logic    advance;
    logic    s_accept;

    // move the held request on when the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    // hold the stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the request payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.command      <= cmd_t'(s_axis_tuser);
            in_item_reg.address      <= s_axis_tdata[5:0];
            in_item_reg.write_data   <= s_axis_tdata[37:6];
            in_item_reg.rx_valid     <= s_axis_tdata[38];
            in_item_reg.rx_byte      <= s_axis_tdata[46:39];
            in_item_reg.cpu_int_open <= s_axis_tdata[47];
        end
    end

    dspr_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .item   (in_item_reg),
        .result (step_result)
    );

    // capture the result
    always_ff @(posedge clk)
    begin
        if (advance)
            out_result_reg <= step_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_result_reg};

endmodule

`default_nettype wire

@@ hdl/dspr_regfile.sv @@
// ----------------------------------------------------------------------------
// dspr_regfile: port registers, interrupt words and per-request update logic
// Holds all architectural state, computes the result of one request in a
// single combinational pass and commits the new state when told to.
// ----------------------------------------------------------------------------
`default_nettype none

module dspr_regfile
    import dspr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    commit,
    input  wire item_t   item,
    output result_t      result
);

    logic [31:0] mode_reg     [PORT_COUNT];
    logic [31:0] status_reg   [PORT_COUNT];
    logic [31:0] transmit_reg [PORT_COUNT];
    logic [31:0] receive_reg  [PORT_COUNT];
    logic [31:0] ien_reg;
    logic [31:0] iflag_reg;

    logic [31:0] mode_next     [PORT_COUNT];
    logic [31:0] status_next   [PORT_COUNT];
    logic [31:0] transmit_next [PORT_COUNT];
    logic [31:0] receive_next  [PORT_COUNT];
    logic [31:0] ien_next;
    logic [31:0] iflag_next;

    logic [1:0] alias_sel;
    logic [1:0] reg_sel;
    logic [1:0] grp_sel;
    logic       port_sel;

    assign alias_sel = item.address[1:0];
    assign reg_sel   = item.address[3:2];
    assign grp_sel   = item.address[5:4];
    assign port_sel  = item.address[4];

    // body replaces, clear and set act at once, invert is dropped
    function automatic logic [31:0] apply_write(
        input logic [31:0] old_val,
        input logic [31:0] data,
        input logic [1:0]  alias_code
    );
        logic [31:0] res;
        unique case (alias_code)
            ALIAS_BODY: res = data;
            ALIAS_CLR:  res = old_val & ~data;
            ALIAS_SET:  res = old_val | data;
            default:    res = old_val;
        endcase
        return res;
    endfunction

    // compute next state and result for the request
    always_comb
    begin
        logic        taken;
        logic [7:0]  rx_char;
        logic [31:0] rd;
        logic        txv [PORT_COUNT];
        logic [7:0]  txb [PORT_COUNT];

        for (int i = 0; i < PORT_COUNT; i++)
        begin
            mode_next[i]     = mode_reg[i];
            status_next[i]   = status_reg[i];
            transmit_next[i] = transmit_reg[i];
            receive_next[i]  = receive_reg[i];
            txv[i]           = 1'b0;
            txb[i]           = 8'd0;
        end
        ien_next   = ien_reg;
        iflag_next = iflag_reg;
        taken      = 1'b0;
        rd         = 32'd0;
        rx_char    = (item.rx_byte == CHAR_LF) ? CHAR_CR : item.rx_byte;
        result     = '0;

        unique case (item.command)
            CMD_WRITE:
            begin
                if (!grp_sel[1])
                begin
                    unique case (reg_sel)
                        REG_MODE:
                            mode_next[port_sel] = apply_write(mode_reg[port_sel],
                                item.write_data, alias_sel);
                        REG_STATUS:
                            status_next[port_sel] = apply_write(status_reg[port_sel],
                                item.write_data, alias_sel);
                        REG_TRANSMIT:
                            transmit_next[port_sel] = apply_write(transmit_reg[port_sel],
                                item.write_data, alias_sel);
                        default:
                            receive_next[port_sel] = apply_write(receive_reg[port_sel],
                                item.write_data, alias_sel);
                    endcase
                end
                else if (reg_sel == REG_MODE)
                begin
                    if (grp_sel == GRP_ENABLE)
                        ien_next = apply_write(ien_reg, item.write_data, alias_sel);
                    else
                        iflag_next = apply_write(iflag_reg, item.write_data, alias_sel);
                end
            end

            CMD_READ:
            begin
                if (alias_sel == ALIAS_BODY)
                begin
                    if (!grp_sel[1])
                    begin
                        unique case (reg_sel)
                            REG_MODE:     rd = mode_reg[port_sel];
                            REG_STATUS:   rd = status_reg[port_sel];
                            REG_TRANSMIT: rd = transmit_reg[port_sel];
                            default:      rd = receive_reg[port_sel];
                        endcase
                    end
                    else if (reg_sel == REG_MODE)
                    begin
                        rd = (grp_sel == GRP_FLAG) ? iflag_reg : ien_reg;
                    end
                end
                result.read_data = rd;
            end

            CMD_TICK:
            begin
                // service each port in order; earlier port wins the offered byte
                for (int i = 0; i < PORT_COUNT; i++)
                begin
                    if (mode_reg[i][MODE_ON_BIT])
                    begin
                        if (status_next[i][STA_UTXEN] && transmit_next[i] != 32'd0)
                        begin
                            if (transmit_next[i] != {24'd0, CHAR_CR})
                            begin
                                txv[i] = 1'b1;
                                txb[i] = transmit_next[i][7:0];
                            end
                            transmit_next[i]          = 32'd0;
                            status_next[i][STA_TRMT]  = 1'b1;
                            iflag_next                = iflag_next | TX_FLAG[i];
                        end
                        if (status_next[i][STA_URXEN] &&
                            (iflag_next & RX_FLAG[i]) == 32'd0)
                        begin
                            status_next[i][STA_URXDA] = 1'b0;
                            if (item.rx_valid && !taken)
                            begin
                                taken                     = 1'b1;
                                receive_next[i]           = {24'd0, rx_char};
                                status_next[i][STA_URXDA] = 1'b1;
                                iflag_next                = iflag_next | RX_FLAG[i];
                            end
                        end
                    end
                end
                result.tx0_valid = txv[0];
                result.tx0_byte  = txb[0];
                result.tx1_valid = txv[1];
                result.tx1_byte  = txb[1];
                result.rx_taken  = taken;
                result.irq_raise = item.cpu_int_open &&
                                   ((iflag_next & ien_reg & FLAG_MASK) != 32'd0);
            end

            default:
            begin
                result = '0;
            end
        endcase
    end

    // commit state when the request advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                mode_reg[i]     <= 32'd0;
                status_reg[i]   <= STATUS_RESET;
                transmit_reg[i] <= 32'd0;
                receive_reg[i]  <= 32'd0;
            end
            ien_reg   <= 32'd0;
            iflag_reg <= 32'd0;
        end
        else if (commit)
        begin
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                mode_reg[i]     <= mode_next[i];
                status_reg[i]   <= status_next[i];
                transmit_reg[i] <= transmit_next[i];
                receive_reg[i]  <= receive_next[i];
            end
            ien_reg   <= ien_next;
            iflag_reg <= iflag_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/dspr_checker.sv @@
// ----------------------------------------------------------------------------
// dspr_checker: port-level checks for the dual serial port registers core
// Watches the stream ports and flags result encodings or stalls that the
// block must never show.
// ----------------------------------------------------------------------------
`default_nettype none

module dspr_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an unsent port reports a zero byte
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32] || m_axis_tdata[40:33] == 8'd0) &&
                          (m_axis_tdata[41] || m_axis_tdata[49:42] == 8'd0))
        else $error("tx byte set without tx valid");

    // read data and tick fields never appear together
    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[31:0] != 32'd0 |->
            m_axis_tdata[55:32] == 24'd0)
        else $error("read data mixed with tick fields");

    // with no request held, the input side is ready
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

bind dual_serial_port_registers_core dspr_checker u_dspr_checker (.*);

`default_nettype wire

@@ tb/tb_dual_serial_port_registers_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_serial_port_registers_core: self-checking bench for the register core
// Walks a short table of directed requests, then about six hundred random and
// port-service requests. A local register model predicts every result; the
// output stream is compared field by field in arrival order. Both stream sides
// idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------

module tb_dual_serial_port_registers_core;

    import dspr_pkg::*;

    // codes the package does not name
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] ALIAS_INV  = 2'd3;
    localparam logic [1:0] GRP_PORT0  = 2'd0;
    localparam logic [1:0] GRP_PORT1  = 2'd1;

    localparam int RANDOM_REQUESTS = 600;
    localparam int CALM_AFTER      = 500;
    localparam int PRESSURE_AT     = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DIRECTED_COUNT  = 25;

    localparam logic [31:0] ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] ON_BIT  = 32'h1 << MODE_ON_BIT;
    localparam logic [31:0] EN_BITS = (32'h1 << STA_UTXEN) | (32'h1 << STA_URXEN);

    // one row of the directed table; want is the typed read_data when typed is set
    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  addr;
        logic [31:0] data;
        logic        rxv;
        logic [7:0]  rxb;
        logic        int_open;
        logic        typed;
        logic [31:0] want;
    } row_t;

    row_t directed_rows [DIRECTED_COUNT] = '{
        // reset values, alias read, out-of-range register reads
        '{CMD_READ,  {GRP_PORT0, REG_STATUS, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b1,
          STATUS_RESET},
        '{CMD_READ,  {GRP_PORT1, REG_STATUS, ALIAS_BODY}, ONES, 1'b1, 8'hFF, 1'b1, 1'b1,
          STATUS_RESET},
        '{CMD_READ,  {GRP_PORT0, REG_MODE, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b1, 32'h0},
        '{CMD_READ,  {GRP_PORT0, REG_STATUS, ALIAS_CLR}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b1, 32'h0},
        '{CMD_WRITE, {GRP_ENABLE, REG_MODE, ALIAS_BODY}, ONES, 1'b1, 8'hFF, 1'b1, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_ENABLE, REG_STATUS, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_READ,  {GRP_ENABLE, REG_MODE, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_READ,  {GRP_FLAG, REG_TRANSMIT, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b1, 32'h0},
        // bring both ports up
        '{CMD_WRITE, {GRP_PORT0, REG_MODE, ALIAS_BODY}, ON_BIT, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_PORT0, REG_STATUS, ALIAS_SET}, EN_BITS, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_PORT0, REG_STATUS, ALIAS_INV}, ONES, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_PORT0, REG_TRANSMIT, ALIAS_BODY}, 32'h41, 1'b0, 8'h00, 1'b0, 1'b0,
          32'h0},
        '{CMD_WRITE, {GRP_PORT1, REG_MODE, ALIAS_SET}, ON_BIT, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_PORT1, REG_STATUS, ALIAS_SET}, EN_BITS, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_PORT1, REG_TRANSMIT, ALIAS_BODY}, 32'(CHAR_CR), 1'b0, 8'h00, 1'b0,
          1'b0, 32'h0},
        // ticks: newline mapping, carriage return swallowed, second port takes over
        '{CMD_TICK,  6'h00, 32'h0, 1'b1, CHAR_LF, 1'b1, 1'b0, 32'h0},
        '{CMD_READ,  {GRP_PORT0, REG_RECEIVE, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_TICK,  6'h00, 32'h0, 1'b1, 8'hFF, 1'b1, 1'b0, 32'h0},
        '{CMD_TICK,  6'h3F, 32'h0, 1'b1, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_FLAG, REG_MODE, ALIAS_CLR}, ONES, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_WRITE, {GRP_PORT0, REG_TRANSMIT, ALIAS_BODY}, ONES, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        '{CMD_TICK,  6'h00, ONES, 1'b1, 8'h00, 1'b1, 1'b0, 32'h0},
        '{CMD_READ,  {GRP_PORT1, REG_STATUS, ALIAS_BODY}, 32'h0, 1'b0, 8'h00, 1'b0, 1'b0, 32'h0},
        // unused command and the top address
        '{CMD_UNUSED, 6'h3F, ONES, 1'b1, 8'hFF, 1'b1, 1'b1, 32'h0},
        '{CMD_READ,  6'h3F, ONES, 1'b1, 8'hFF, 1'b1, 1'b1, 32'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    // register model state
    logic [31:0] mode_reg   [PORT_COUNT];
    logic [31:0] status_reg [PORT_COUNT];
    logic [31:0] txd_reg    [PORT_COUNT];
    logic [31:0] rxd_reg    [PORT_COUNT];
    logic [31:0] int_enable;
    logic [31:0] int_flags;

    result_t due_results [$];
    int      mismatches = 0;
    int      requests_sent;
    int      quiet_cycles = 0;
    bit      calm;

    dual_serial_port_registers_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // body of an addressed register; unmapped slots read as zero
    function automatic logic [31:0] reg_body(logic [1:0] grp, logic [1:0] rsel);
        if (grp == GRP_ENABLE)
            return (rsel == REG_MODE) ? int_enable : 32'h0;
        if (grp == GRP_FLAG)
            return (rsel == REG_MODE) ? int_flags : 32'h0;
        case (rsel)
            REG_MODE:     return mode_reg[grp[0]];
            REG_STATUS:   return status_reg[grp[0]];
            REG_TRANSMIT: return txd_reg[grp[0]];
            default:      return rxd_reg[grp[0]];
        endcase
    endfunction

    // apply one request to the register model and return its result
    function automatic result_t step_ports(item_t it);
        result_t     r;
        logic [1:0]  grp;
        logic [1:0]  rsel;
        logic [1:0]  asel;
        logic [31:0] nv;
        bit          taken;
        r     = '0;
        grp   = it.address[5:4];
        rsel  = it.address[3:2];
        asel  = it.address[1:0];
        taken = 1'b0;
        case (it.command)
            CMD_WRITE:
            begin
                nv = reg_body(grp, rsel);
                case (asel)
                    ALIAS_BODY: nv = it.write_data;
                    ALIAS_CLR:  nv = nv & ~it.write_data;
                    ALIAS_SET:  nv = nv | it.write_data;
                    default:    ;
                endcase
                if (grp == GRP_ENABLE)
                begin
                    if (rsel == REG_MODE)
                        int_enable = nv;
                end
                else if (grp == GRP_FLAG)
                begin
                    if (rsel == REG_MODE)
                        int_flags = nv;
                end
                else
                begin
                    case (rsel)
                        REG_MODE:     mode_reg[grp[0]]   = nv;
                        REG_STATUS:   status_reg[grp[0]] = nv;
                        REG_TRANSMIT: txd_reg[grp[0]]    = nv;
                        default:      rxd_reg[grp[0]]    = nv;
                    endcase
                end
            end
            CMD_READ:
            begin
                if (asel == ALIAS_BODY)
                    r.read_data = reg_body(grp, rsel);
            end
            CMD_TICK:
            begin
                for (int p = 0; p < PORT_COUNT; p++)
                begin
                    if (mode_reg[p][MODE_ON_BIT])
                    begin
                        // transmit: carriage return is dropped but still completes
                        if (status_reg[p][STA_UTXEN] && txd_reg[p] != 32'h0)
                        begin
                            if (txd_reg[p] != 32'(CHAR_CR))
                            begin
                                if (p == 0)
                                begin
                                    r.tx0_valid = 1'b1;
                                    r.tx0_byte  = txd_reg[p][7:0];
                                end
                                else
                                begin
                                    r.tx1_valid = 1'b1;
                                    r.tx1_byte  = txd_reg[p][7:0];
                                end
                            end
                            txd_reg[p]              = 32'h0;
                            status_reg[p][STA_TRMT] = 1'b1;
                            int_flags               = int_flags | TX_FLAG[p];
                        end
                        // receive: only while the port's receive flag is clear
                        if (status_reg[p][STA_URXEN] && (int_flags & RX_FLAG[p]) == 32'h0)
                        begin
                            status_reg[p][STA_URXDA] = 1'b0;
                            if (it.rx_valid && !taken)
                            begin
                                taken      = 1'b1;
                                rxd_reg[p] = (it.rx_byte == CHAR_LF) ? 32'(CHAR_CR)
                                                                     : 32'(it.rx_byte);
                                status_reg[p][STA_URXDA] = 1'b1;
                                int_flags = int_flags | RX_FLAG[p];
                            end
                        end
                    end
                end
                r.rx_taken  = taken;
                r.irq_raise = it.cpu_int_open && ((int_flags & int_enable & FLAG_MASK) != 0);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic item_t make_request(logic [1:0] cmd, logic [5:0] addr,
                                           logic [31:0] data);
        item_t it;
        it.command      = cmd_t'(cmd);
        it.address      = addr;
        it.write_data   = data;
        it.rx_valid     = 1'($urandom);
        it.rx_byte      = 8'($urandom);
        it.cpu_int_open = 1'($urandom);
        return it;
    endfunction

    // random request, shaped so ports stay mostly on and enabled
    function automatic item_t random_request();
        item_t       it;
        int unsigned roll;
        logic [1:0]  grp;
        logic [1:0]  rsel;
        logic [1:0]  asel;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            it.command = CMD_TICK;
        else if (roll < 67)
            it.command = CMD_WRITE;
        else if (roll < 97)
            it.command = CMD_READ;
        else
            it.command = cmd_t'(CMD_UNUSED);

        roll = $urandom_range(0, 99);
        grp  = (roll < 38) ? GRP_PORT0 : (roll < 76) ? GRP_PORT1 :
               (roll < 88) ? GRP_ENABLE : GRP_FLAG;
        rsel = 2'($urandom);
        if (grp[1] && $urandom_range(0, 9) != 0)
            rsel = REG_MODE;
        roll = $urandom_range(0, 99);
        asel = (roll < 55) ? ALIAS_BODY : (roll < 75) ? ALIAS_CLR :
               (roll < 92) ? ALIAS_SET : ALIAS_INV;
        if (grp == GRP_FLAG && $urandom_range(0, 1) != 0)
            asel = ALIAS_CLR;
        it.address = {grp, rsel, asel};

        // data: extremes, or biased toward the bits that matter for the target
        roll = $urandom_range(0, 9);
        if (roll == 0)
            it.write_data = ONES;
        else if (roll == 1)
            it.write_data = 32'h0;
        else if (grp[1])
            it.write_data = $urandom | ((roll < 6) ? FLAG_MASK : 32'h0);
        else
        begin
            case (rsel)
                REG_MODE:   it.write_data = $urandom | ((roll < 8) ? ON_BIT : 32'h0);
                REG_STATUS: it.write_data = $urandom | ((roll < 8) ? EN_BITS : 32'h0);
                REG_TRANSMIT:
                begin
                    if (roll < 4)
                        it.write_data = 32'((roll == 2) ? CHAR_CR : CHAR_LF);
                    else if (roll < 8)
                        it.write_data = 32'($urandom_range(1, 255));
                    else
                        it.write_data = $urandom;
                end
                default:    it.write_data = $urandom;
            endcase
        end

        it.rx_valid = ($urandom_range(0, 3) != 0);
        roll = $urandom_range(0, 9);
        it.rx_byte = (roll < 2) ? CHAR_LF : (roll < 3) ? CHAR_CR : 8'($urandom);
        it.cpu_int_open = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    // offer one request, hold it until taken, then record its expected result
    task automatic send_request(item_t it, logic typed, logic [31:0] want_read);
        result_t want;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.command;
        s_axis_tdata  <= {it.cpu_int_open, it.rx_byte, it.rx_valid, it.write_data,
                          it.address};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        want = step_ports(it);
        if (typed)
        begin
            want           = '0;
            want.read_data = want_read;
        end
        due_results.push_back(want);
        requests_sent++;
    endtask

    // drop valid for a random burst now and then
    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // compare each returned result with the oldest outstanding one
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[51:0]);
            if (due_results.size() == 0)
            begin
                $error("result 0x%0h arrived with nothing outstanding", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("tx0_valid", 32'(want.tx0_valid), 32'(got.tx0_valid));
                check_field("tx0_byte",  32'(want.tx0_byte),  32'(got.tx0_byte));
                check_field("tx1_valid", 32'(want.tx1_valid), 32'(got.tx1_valid));
                check_field("tx1_byte",  32'(want.tx1_byte),  32'(got.tx1_byte));
                check_field("rx_taken",  32'(want.rx_taken),  32'(got.rx_taken));
                check_field("irq_raise", 32'(want.irq_raise), 32'(got.irq_raise));
            end
        end
    end

    // end the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("dual_serial_port_registers_core verification failed");
                $finish;
            end
        end
    end

    // result side: stall in random bursts until the calm tail
    initial
    begin
        m_axis_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        row_t        row;
        int unsigned p;
        logic [1:0]  pgrp;
        bit          pressure_done;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_WRITE;
        requests_sent = 0;
        calm          = 1'b0;
        pressure_done = 1'b0;
        for (int i = 0; i < PORT_COUNT; i++)
        begin
            mode_reg[i]   = 32'h0;
            status_reg[i] = STATUS_RESET;
            txd_reg[i]    = 32'h0;
            rxd_reg[i]    = 32'h0;
        end
        int_enable = 32'h0;
        int_flags  = 32'h0;

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = directed_rows[i];
            maybe_idle();
            send_request('{cpu_int_open: row.int_open, rx_byte: row.rxb, rx_valid: row.rxv,
                           write_data: row.data, address: row.addr,
                           command: cmd_t'(row.cmd)}, row.typed, row.want);
        end
        drain();

        // random requests mixed with port-service sequences
        requests_sent = 0;
        while (requests_sent < RANDOM_REQUESTS)
        begin
            if (!pressure_done && requests_sent >= PRESSURE_AT)
            begin
                drain();
                pressure_done = 1'b1;
            end
            if (requests_sent >= CALM_AFTER)
                calm = 1'b1;
            maybe_idle();
            if ($urandom_range(0, 4) == 0)
            begin
                // service one port: read status and data, clear its flags, reload
                p    = $urandom_range(0, PORT_COUNT - 1);
                pgrp = (p == 0) ? GRP_PORT0 : GRP_PORT1;
                send_request(make_request(CMD_READ, {pgrp, REG_STATUS, ALIAS_BODY}, $urandom),
                             1'b0, 32'h0);
                maybe_idle();
                send_request(make_request(CMD_READ, {pgrp, REG_RECEIVE, ALIAS_BODY}, $urandom),
                             1'b0, 32'h0);
                maybe_idle();
                send_request(make_request(CMD_WRITE, {GRP_FLAG, REG_MODE, ALIAS_CLR},
                                          RX_FLAG[p] | TX_FLAG[p]), 1'b0, 32'h0);
                maybe_idle();
                send_request(make_request(CMD_WRITE, {pgrp, REG_TRANSMIT, ALIAS_BODY},
                                          32'($urandom_range(0, 255))), 1'b0, 32'h0);
            end
            else
                send_request(random_request(), 1'b0, 32'h0);
        end

        // let the pipeline empty, then keep watching for stray results
        drain();
        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("dual_serial_port_registers_core verification clean");
        else
            $display("dual_serial_port_registers_core verification failed");
        $finish;
    end

endmodule
